/* hw/rtl/iee_pkg.sv */
// Package for the Ising energy evaluator: request modes, field widths
// and output range limits. No dependencies.
package iee_pkg;

  // Request modes
  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_EVAL  = 1'b1
  } mode_e;

  localparam int unsigned COEF_W       = 16;  // signed Q8.8 coefficient
  localparam int unsigned INDEX_W      = 8;   // coefficient slot index
  localparam int unsigned SPIN_FIELD_W = 16;  // width of the spin vector
  localparam int unsigned ENERGY_W     = 24;  // signed Q16.8 energy

  localparam int ENERGY_MAX = 8388607;
  localparam int ENERGY_MIN = -8388608;

endpackage

/* hw/rtl/iee_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iee_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 136
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/ising_energy_evaluator.sv */
// Ising energy evaluator top level: coefficient RAM plus a sequencer that
// walks it with one shared add/subtract accumulator. Uses iee_pkg, iee_ram.
//
//  Channel | Handshake                 | Payload
//  --------+---------------------------+---------------------------------------
//  in      | in_valid_i / in_ready_o   | mode_i, coef_index_i, coef_value_i,
//          |                           | spins_i
//  out     | out_valid_o / out_ready_i | energy_o
//
// A write request gives no result.
// An evaluate request makes one RAM read per coefficient into a single
// accumulator, drains the last read, then negates and saturates; the
// next request can be accepted in the cycle after that final step.
// in_ready_o is high only while the sequencer is idle; a finished result
// waits in the output register, and a new evaluation stalls in its final
// step until that register is free. Reset clears the sequencer, accumulator
// and output registers; the coefficient RAM holds garbage until written.
module ising_energy_evaluator
  import iee_pkg::*;
#(
  parameter int unsigned SPINS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       mode_i,
  input  logic [INDEX_W-1:0]         coef_index_i,
  input  logic signed [COEF_W-1:0]   coef_value_i,
  input  logic [SPIN_FIELD_W-1:0]    spins_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [ENERGY_W-1:0] energy_o
);

  localparam int unsigned PAIR_COUNT = SPINS * (SPINS - 1) / 2;
  localparam int unsigned COEF_COUNT = PAIR_COUNT + SPINS;
  localparam int unsigned AW         = $clog2(COEF_COUNT);
  localparam int unsigned IW         = $clog2(SPINS);
  localparam int unsigned SUMW       = $clog2(COEF_COUNT) + COEF_W + 1;
  localparam int unsigned EXTW       = ((SUMW > ENERGY_W) ? SUMW : ENERGY_W) + 1;

  localparam logic signed [EXTW-1:0] E_MAX = EXTW'(ENERGY_MAX);
  localparam logic signed [EXTW-1:0] E_MIN = EXTW'(ENERGY_MIN);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_DONE
  } state_e;

  state_e                       state_q;
  logic [AW-1:0]                slot_q;
  logic [IW-1:0]                i_q;
  logic [IW-1:0]                j_q;
  logic                         fld_q;
  logic [SPIN_FIELD_W-1:0]      spins_q;
  logic                         rd_vld_q;
  logic                         sgn_q;
  logic signed [SUMW-1:0]       acc_q;
  logic signed [SUMW-1:0]       acc_d;
  logic                         out_valid_q;
  logic signed [ENERGY_W-1:0]   energy_q;
  logic signed [ENERGY_W-1:0]   energy_d;

  logic                         in_acc;
  logic                         we;
  logic [AW-1:0]                waddr;
  logic [COEF_W-1:0]            rdata;
  logic signed [SUMW-1:0]       coef_ext;
  logic                         spin_i;
  logic                         spin_j;
  logic                         sgn_d;
  logic signed [EXTW-1:0]       acc_ext;
  logic signed [EXTW-1:0]       neg_ext;
  logic                         out_free;

  // Spin lookup; spins past the vector read as -1
  function automatic logic spin_up(logic [SPIN_FIELD_W-1:0] s, logic [IW-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    if (wide < SPIN_FIELD_W) begin
      return s[wide[$clog2(SPIN_FIELD_W)-1:0]];
    end
    return 1'b0;
  endfunction

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // Coefficient write: slots past the table are dropped
  assign we    = in_acc && (mode_i == MODE_WRITE) && (32'(coef_index_i) < COEF_COUNT);
  assign waddr = AW'(32'(coef_index_i));

  iee_ram #(
    .WIDTH (COEF_W),
    .DEPTH (COEF_COUNT)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (coef_value_i),
    .raddr_i (slot_q),
    .rdata_o (rdata)
  );

  // Sign of the term issued this cycle: 1 adds, 0 subtracts
  assign spin_i = spin_up(spins_q, i_q);
  assign spin_j = spin_up(spins_q, j_q);
  assign sgn_d  = fld_q ? spin_i : (spin_i == spin_j);

  // Shared accumulator
  assign coef_ext = SUMW'($signed(rdata));
  assign acc_d    = sgn_q ? (acc_q + coef_ext) : (acc_q - coef_ext);

  // Negate and saturate to the output range
  assign acc_ext = EXTW'(acc_q);
  assign neg_ext = -acc_ext;
  always_comb begin
    if (neg_ext > E_MAX) begin
      energy_d = E_MAX[ENERGY_W-1:0];
    end else if (neg_ext < E_MIN) begin
      energy_d = E_MIN[ENERGY_W-1:0];
    end else begin
      energy_d = neg_ext[ENERGY_W-1:0];
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  // Sequencer, accumulator and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slot_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      fld_q       <= 1'b0;
      spins_q     <= '0;
      rd_vld_q    <= 1'b0;
      sgn_q       <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      energy_q    <= '0;
    end else begin
      // Read data arrives in the cycle after each issued address
      rd_vld_q <= (state_q == S_RUN);
      if (rd_vld_q) begin
        acc_q <= acc_d;
      end

      // Output valid: set by the final step, cleared when taken
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc && (mode_i == MODE_EVAL)) begin
            state_q <= S_RUN;
            slot_q  <= '0;
            i_q     <= '0;
            j_q     <= IW'(1);
            fld_q   <= 1'b0;
            spins_q <= spins_i;
            acc_q   <= '0;
          end
        end
        S_RUN: begin
          sgn_q    <= sgn_d;
          slot_q   <= slot_q + AW'(1);
          if (fld_q) begin
            if (i_q == IW'(SPINS - 1)) begin
              state_q <= S_DRAIN;
            end else begin
              i_q <= i_q + IW'(1);
            end
          end else if (j_q == IW'(SPINS - 1)) begin
            // End of a coupling row
            if (i_q == IW'(SPINS - 2)) begin
              fld_q <= 1'b1;
              i_q   <= '0;
            end else begin
              i_q <= i_q + IW'(1);
              j_q <= i_q + IW'(2);
            end
          end else begin
            j_q <= j_q + IW'(1);
          end
        end
        S_DRAIN: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            energy_q    <= energy_d;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign energy_o    = energy_q;

  // Read data is only accumulated for addresses issued by the walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q == S_RUN))
    else $error("accumulate without a preceding read");

  // An accepted evaluation starts the walk at the first slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (mode_i == MODE_EVAL)) |=> (state_q == S_RUN) && (slot_q == '0) && !fld_q)
    else $error("evaluation did not start at slot zero");

  // A result is only produced at the end of a walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result outside the final step");

  // Field phase: slot counter and spin counter agree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fld_q && (state_q == S_RUN)) |-> (32'(slot_q) == PAIR_COUNT + 32'(i_q)))
    else $error("field slot out of step with spin index");

endmodule

/* verif/tb_ising_energy_evaluator.sv */
// Testbench for ising_energy_evaluator: coefficient writes and energy
// evaluations checked against a local energy predictor under random stalls.
// Depends on iee_pkg and the ising_energy_evaluator RTL.
module tb_ising_energy_evaluator;
  import iee_pkg::*;

  localparam int SPIN_COUNT   = 16;
  localparam int PAIR_SLOTS   = SPIN_COUNT * (SPIN_COUNT - 1) / 2;
  localparam int COEF_SLOTS   = PAIR_SLOTS + SPIN_COUNT;
  localparam int EVAL_LATENCY = COEF_SLOTS + 3;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 1040;
  localparam int PHASES       = 4;

  typedef logic signed [ENERGY_W-1:0] energy_t;

  // Directed row kinds: fill the whole table, write one slot, evaluate
  typedef enum logic [1:0] {
    ROW_FILL,
    ROW_WRITE,
    ROW_EVAL
  } row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [INDEX_W-1:0] index;
    logic [COEF_W-1:0]  value;
    logic [SPIN_FIELD_W-1:0] spins;
    bit                typed;   // energy below is known by hand
    int                energy;
  } stim_row_t;

  localparam int DIR_ROWS = 25;

  // Uniform tables and a single written slot give closed-form energies; the rest use the predictor
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_FILL,  8'd0,   16'h8000, 16'h0000, 1'b0, 0},
    '{ROW_EVAL,  8'd0,   16'h0000, 16'hFFFF, 1'b1, 4456448},
    '{ROW_EVAL,  8'hFF,  16'hFFFF, 16'h0000, 1'b1, 3407872},
    '{ROW_FILL,  8'd0,   16'h7FFF, 16'h0000, 1'b0, 0},
    '{ROW_EVAL,  8'd135, 16'h8000, 16'hFFFF, 1'b1, -4456312},
    '{ROW_EVAL,  8'd0,   16'h0000, 16'h0000, 1'b1, -3407768},
    '{ROW_FILL,  8'd0,   16'h0000, 16'hFFFF, 1'b0, 0},
    '{ROW_EVAL,  8'd77,  16'h5555, 16'h5A5A, 1'b1, 0},
    '{ROW_WRITE, 8'd0,   16'h0100, 16'hFFFF, 1'b0, 0},
    '{ROW_EVAL,  8'd0,   16'h0000, 16'h0003, 1'b1, -256},
    '{ROW_EVAL,  8'd0,   16'h0000, 16'h0001, 1'b1, 256},
    '{ROW_WRITE, 8'd119, 16'h8000, 16'hAAAA, 1'b0, 0},
    '{ROW_WRITE, 8'd135, 16'h7FFF, 16'h5555, 1'b0, 0},
    '{ROW_WRITE, 8'd120, 16'h7FFF, 16'h0000, 1'b0, 0},
    '{ROW_WRITE, 8'd14,  16'hFFFF, 16'h1234, 1'b0, 0},
    '{ROW_EVAL,  8'd136, 16'h7FFF, 16'hFFFF, 1'b0, 0},
    '{ROW_EVAL,  8'd255, 16'h8000, 16'h8001, 1'b0, 0},
    // out-of-range slots must not land in the table
    '{ROW_WRITE, 8'd136, 16'h1234, 16'h0000, 1'b0, 0},
    '{ROW_WRITE, 8'd255, 16'h8000, 16'hFFFF, 1'b0, 0},
    '{ROW_WRITE, 8'd200, 16'h7FFF, 16'h0F0F, 1'b0, 0},
    '{ROW_EVAL,  8'd0,   16'h0000, 16'hFFFF, 1'b0, 0},
    '{ROW_EVAL,  8'd0,   16'h0000, 16'h0000, 1'b0, 0},
    '{ROW_EVAL,  8'd0,   16'h0000, 16'h7FFE, 1'b0, 0},
    '{ROW_WRITE, 8'd1,   16'h0001, 16'h0000, 1'b0, 0},
    '{ROW_EVAL,  8'd1,   16'h0001, 16'hC3A5, 1'b0, 0}
  };

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic                        mode_i;
  logic [INDEX_W-1:0]          coef_index_i;
  logic signed [COEF_W-1:0]    coef_value_i;
  logic [SPIN_FIELD_W-1:0]     spins_i;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic signed [ENERGY_W-1:0]  energy_o;

  // Predictor state and expected energies in request order
  logic signed [COEF_W-1:0] coef_q [COEF_SLOTS];
  energy_t                  energy_due_q [$];
  int                       mismatch_count = 0;
  int                       cycle_count = 0;
  int                       send_idle_pct = 0;
  int                       recv_stall_pct = 0;

  ising_energy_evaluator #(
    .SPINS (SPIN_COUNT)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .coef_index_i (coef_index_i),
    .coef_value_i (coef_value_i),
    .spins_i      (spins_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .energy_o     (energy_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic bit spin_up(logic [SPIN_FIELD_W-1:0] s, int i);
    return (i < SPIN_FIELD_W) && s[i];
  endfunction

  // Energy of a spin vector over the current table, saturated to 24 bits
  function automatic energy_t ising_energy(logic [SPIN_FIELD_W-1:0] s);
    int acc;
    int slot;
    acc  = 0;
    slot = 0;
    for (int i = 0; i < SPIN_COUNT; i++) begin
      for (int j = i + 1; j < SPIN_COUNT; j++) begin
        if (spin_up(s, i) == spin_up(s, j)) acc += coef_q[slot];
        else acc -= coef_q[slot];
        slot++;
      end
      if (spin_up(s, i)) acc += coef_q[PAIR_SLOTS + i];
      else acc -= coef_q[PAIR_SLOTS + i];
    end
    acc = -acc;
    if (acc > ENERGY_MAX) acc = ENERGY_MAX;
    if (acc < ENERGY_MIN) acc = ENERGY_MIN;
    return energy_t'(acc);
  endfunction

  // Drive one request, hold it until accepted, then update the predictor
  task automatic send_request(mode_e m, logic [INDEX_W-1:0] idx,
                              logic [COEF_W-1:0] val, logic [SPIN_FIELD_W-1:0] sp,
                              bit typed, int typed_energy);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= m;
    coef_index_i <= idx;
    coef_value_i <= val;
    spins_i      <= sp;
    do @(posedge clk_i); while (!in_ready_o);
    if (m == MODE_WRITE) begin
      if (idx < COEF_SLOTS) coef_q[idx] = val;
    end else begin
      energy_due_q.push_back(typed ? energy_t'(typed_energy) : ising_energy(sp));
    end
  endtask

  task automatic fill_table(logic [COEF_W-1:0] val);
    for (int k = 0; k < COEF_SLOTS; k++) begin
      send_request(MODE_WRITE, INDEX_W'(k), val, SPIN_FIELD_W'($urandom), 1'b0, 0);
    end
  endtask

  // Stop sending until every pending energy is back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (energy_due_q.size() != 0) @(posedge clk_i);
    repeat (EVAL_LATENCY + 10) @(posedge clk_i);
  endtask

  function automatic logic [COEF_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic logic [SPIN_FIELD_W-1:0] pick_spins();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return SPIN_FIELD_W'($urandom);
    endcase
  endfunction

  // Receiver readiness, redrawn every falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result check against the oldest pending energy
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (energy_due_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual energy %0d",
                 $time, energy_o);
        mismatch_count++;
      end else begin
        if (energy_o !== energy_due_q[0]) begin
          $display("%0t: energy mismatch, expected %0d, actual %0d",
                   $time, energy_due_q[0], energy_o);
          mismatch_count++;
        end
        void'(energy_due_q.pop_front());
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run limit reached with %0d results pending",
               $time, energy_due_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Main stimulus
  initial begin
    bit                      do_eval;
    logic [INDEX_W-1:0]      idx;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    mode_i       = MODE_WRITE;
    coef_index_i = '0;
    coef_value_i = '0;
    spins_i      = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table; fills keep every slot written before any read
    foreach (dir_rows[r]) begin
      case (dir_rows[r].kind)
        ROW_FILL:  fill_table(dir_rows[r].value);
        ROW_WRITE: send_request(MODE_WRITE, dir_rows[r].index, dir_rows[r].value,
                                dir_rows[r].spins, 1'b0, 0);
        default:   send_request(MODE_EVAL, dir_rows[r].index, dir_rows[r].value,
                                dir_rows[r].spins, dir_rows[r].typed,
                                dir_rows[r].energy);
      endcase
    end

    // Random phases: no idling, sender idle, receiver stall, both
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        do_eval = ($urandom_range(99) < 30);
        if (do_eval) begin
          send_request(MODE_EVAL, INDEX_W'($urandom), COEF_W'($urandom),
                       pick_spins(), 1'b0, 0);
        end else begin
          if ($urandom_range(19) == 0) idx = INDEX_W'($urandom_range(255, COEF_SLOTS));
          else idx = INDEX_W'($urandom_range(COEF_SLOTS - 1));
          send_request(MODE_WRITE, idx, pick_value(), SPIN_FIELD_W'($urandom),
                       1'b0, 0);
        end
      end
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
